// ===== src/ccfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC checked frame receiver package
// Shared types, framing constants and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package ccfr_pkg;

	localparam logic [7:0]  MAGIC_FIRST  = 8'hBB;
	localparam logic [7:0]  MAGIC_SECOND = 8'hC1;
	localparam logic [15:0] CRC_POLY     = 16'h1021;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam int          FRAME_LEN_W  = 9;
	localparam int          READ_SPAN    = 256;

	localparam logic OP_FEED = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_OK      = 2'd1,
		EV_TOO_BIG = 2'd2,
		EV_CRC_BAD = 2'd3
	} event_t;

	// Outcome of one received byte, as seen by the output stage.
	typedef struct packed {
		event_t                 ev;
		logic [7:0]             kind;
		logic [15:0]            seq;
		logic [FRAME_LEN_W-1:0] length;
		logic                   wr_en;
	} parse_res_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== src/ccfr_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser
// Hunts for the magic, collects the header, counts payload bytes, keeps the
// running CRC and judges the frame when both check bytes are in.
// ----------------------------------------------------------------------------
module ccfr_parser #(
	parameter int MAX_PAYLOAD = 256,
	localparam int PCW = $clog2(MAX_PAYLOAD + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 feed,
	input  logic [7:0]           byte_in,
	output ccfr_pkg::parse_res_t res,
	output logic [PCW-1:0]       pay_idx
);
	import ccfr_pkg::*;

	typedef enum logic [4:0] {
		PH_MAGIC0  = 5'b00001,
		PH_MAGIC1  = 5'b00010,
		PH_HEADER  = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_CHECK   = 5'b10000
	} phase_t;

	phase_t         phase_q, phase_d;
	logic [2:0]     hdr_cnt_q, hdr_cnt_d;
	logic [7:0]     kind_q, kind_d;
	logic [31:0]    len_q, len_d;
	logic [15:0]    seq_q, seq_d;
	logic [PCW-1:0] pay_cnt_q, pay_cnt_d, pay_cnt_inc;
	logic [7:0]     crc_lo_q, crc_lo_d;
	logic           crc_cnt_q, crc_cnt_d;
	logic [15:0]    crc_q, crc_d, crc_upd;

	assign crc_upd     = crc16_byte(crc_q, byte_in);
	assign pay_cnt_inc = pay_cnt_q + 1'b1;
	assign pay_idx     = pay_cnt_q;

	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		kind_d    = kind_q;
		len_d     = len_q;
		seq_d     = seq_q;
		pay_cnt_d = pay_cnt_q;
		crc_lo_d  = crc_lo_q;
		crc_cnt_d = crc_cnt_q;
		crc_d     = crc_q;
		res       = '0;
		res.ev    = EV_NONE;
		case (phase_q)
			PH_MAGIC1: begin
				if (byte_in == MAGIC_SECOND) begin
					hdr_cnt_d = '0;
					crc_d     = CRC_INIT;
					phase_d   = PH_HEADER;
				end else if (byte_in != MAGIC_FIRST) begin
					phase_d = PH_MAGIC0;
				end
			end
			PH_HEADER: begin
				crc_d     = crc_upd;
				hdr_cnt_d = hdr_cnt_q + 1'b1;
				case (hdr_cnt_q)
					3'd0: kind_d = byte_in;
					3'd1: ;
					3'd2: len_d = {24'h0, byte_in};
					3'd3: len_d[15:8] = byte_in;
					3'd4: len_d[23:16] = byte_in;
					3'd5: len_d[31:24] = byte_in;
					3'd6: seq_d = {8'h00, byte_in};
					default: seq_d[15:8] = byte_in;
				endcase
				// The length is complete by the last header byte.
				if (hdr_cnt_q == 3'd7) begin
					if (len_q > 32'(MAX_PAYLOAD)) begin
						res.ev    = EV_TOO_BIG;
						res.seq   = seq_d;
						phase_d   = PH_MAGIC0;
						hdr_cnt_d = '0;
						pay_cnt_d = '0;
						len_d     = '0;
						seq_d     = '0;
						crc_lo_d  = '0;
						crc_cnt_d = 1'b0;
						crc_d     = CRC_INIT;
					end else if (len_q == 32'd0) begin
						phase_d = PH_CHECK;
					end else begin
						pay_cnt_d = '0;
						phase_d   = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				res.wr_en = 1'b1;
				pay_cnt_d = pay_cnt_inc;
				crc_d     = crc_upd;
				if (32'(pay_cnt_inc) >= len_q) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				if (!crc_cnt_q) begin
					crc_lo_d  = byte_in;
					crc_cnt_d = 1'b1;
				end else begin
					res.kind = kind_q;
					res.seq  = seq_q;
					if ({byte_in, crc_lo_q} == crc_q) begin
						res.ev     = EV_OK;
						res.length = len_q[FRAME_LEN_W-1:0];
					end else begin
						res.ev = EV_CRC_BAD;
					end
					phase_d   = PH_MAGIC0;
					hdr_cnt_d = '0;
					pay_cnt_d = '0;
					len_d     = '0;
					seq_d     = '0;
					crc_lo_d  = '0;
					crc_cnt_d = 1'b0;
					crc_d     = CRC_INIT;
				end
			end
			default: begin
				phase_d = (byte_in == MAGIC_FIRST) ? PH_MAGIC1 : PH_MAGIC0;
			end
		endcase
		if (!feed) begin
			res.ev    = EV_NONE;
			res.kind  = '0;
			res.seq   = '0;
			res.length = '0;
			res.wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_MAGIC0;
			hdr_cnt_q <= '0;
			kind_q    <= '0;
			len_q     <= '0;
			seq_q     <= '0;
			pay_cnt_q <= '0;
			crc_lo_q  <= '0;
			crc_cnt_q <= 1'b0;
			crc_q     <= CRC_INIT;
		end else if (feed) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			kind_q    <= kind_d;
			len_q     <= len_d;
			seq_q     <= seq_d;
			pay_cnt_q <= pay_cnt_d;
			crc_lo_q  <= crc_lo_d;
			crc_cnt_q <= crc_cnt_d;
			crc_q     <= crc_d;
		end
	end

endmodule

// ===== src/crc_checked_frame_receiver.sv =====
`timescale 1ns / 1ps
// Latency: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle; in_ready is high while the output register
// is empty or being taken, so a stalled result blocks only the next item.
// Reset: arst_n clears parser state, CRC and output valid asynchronously; the
// payload buffer is not cleared and its entries hold junk until written.
// ----------------------------------------------------------------------------
// CRC checked frame receiver
// Byte-wise frame parser with CRC-16 check and a readable payload buffer.
// ----------------------------------------------------------------------------
module crc_checked_frame_receiver #(
	parameter int MAX_PAYLOAD = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             op,
	input  logic [7:0]       byte_in,
	input  logic [7:0]       read_index,
	output logic             out_valid,
	input  logic             out_ready,
	output ccfr_pkg::event_t event_res,
	output logic [7:0]       frame_kind,
	output logic [15:0]      frame_seq,
	output logic [8:0]       frame_length,
	output logic [7:0]       read_data
);
	import ccfr_pkg::*;

	localparam int PCW         = $clog2(MAX_PAYLOAD + 1);
	localparam int STORE_DEPTH = (MAX_PAYLOAD < READ_SPAN) ? MAX_PAYLOAD : READ_SPAN;
	localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	logic           acc, feed, rd_hit;
	parse_res_t     res;
	logic [PCW-1:0] pay_idx;
	logic [7:0]     mem [STORE_DEPTH];

	logic           out_valid_q;
	event_t         ev_s1;
	logic [7:0]     kind_s1;
	logic [15:0]    seq_s1;
	logic [8:0]     len_s1;
	logic           rd_en_s1;
	logic [7:0]     rd_mem_s1;

	assign in_ready = !out_valid_q || out_ready;
	assign acc      = in_valid && in_ready;
	assign feed     = acc && (op == OP_FEED);
	assign rd_hit   = (op == OP_READ) && (32'(read_index) < 32'(MAX_PAYLOAD));

	ccfr_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.feed    (feed),
		.byte_in (byte_in),
		.res     (res),
		.pay_idx (pay_idx)
	);

	// Payload bytes past the readable span are counted but not stored.
	always_ff @(posedge clk) begin
		if (feed && res.wr_en && (32'(pay_idx) < 32'(STORE_DEPTH))) begin
			mem[pay_idx[AW-1:0]] <= byte_in;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && rd_hit) begin
			rd_mem_s1 <= mem[read_index[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ev_s1    <= res.ev;
			kind_s1  <= res.kind;
			seq_s1   <= res.seq;
			len_s1   <= res.length;
			rd_en_s1 <= rd_hit;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = ev_s1;
	assign frame_kind   = kind_s1;
	assign frame_seq    = seq_s1;
	assign frame_length = len_s1;
	assign read_data    = rd_en_s1 ? rd_mem_s1 : 8'h00;

endmodule

// ===== src/ccfr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver port checker
// Watches the top-level ports for result consistency and handshake timing.
// ----------------------------------------------------------------------------
module ccfr_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             op,
	input logic             out_valid,
	input logic             out_ready,
	input ccfr_pkg::event_t event_res,
	input logic [7:0]       frame_kind,
	input logic [15:0]      frame_seq,
	input logic [8:0]       frame_length,
	input logic [7:0]       read_data
);
	import ccfr_pkg::*;

	// A stalled result must not change under the consumer.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(frame_seq)
			&& $stable(frame_length) && $stable(read_data))
		else $error("result changed while stalled");

	// A buffer read never reports a frame event, and its result is valid in the following cycle.
	a_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == OP_READ |=> out_valid && event_res == EV_NONE)
		else $error("read transaction produced an event or no result");

	// A received byte never returns buffer data.
	a_feed: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == OP_FEED |=> out_valid && read_data == 8'h00)
		else $error("byte transaction returned buffer data");

	// Only an accepted frame carries a length.
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_OK |-> frame_length == 9'd0)
		else $error("length reported without an accepted frame");

	// Quiet results carry no frame identity.
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_NONE |-> frame_kind == 8'h00 && frame_seq == 16'h0000)
		else $error("frame fields set without an event");

endmodule

bind crc_checked_frame_receiver ccfr_checker u_ccfr_checker (.*);

// ===== tb/ccfr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC checked frame receiver checker
// Watches both channels of the receiver, runs a cycle-free model of the
// frame parser on every accepted input transaction and compares each
// accepted result, in order, with the value the model predicts.
// ----------------------------------------------------------------------------
package ccfr_tb_lib;

	import ccfr_pkg::*;

	// Bit-serial form of the CRC-16 register, MSB first.
	function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ data[i];
			c  = {c[14:0], 1'b0};
			if (fb)
				c = c ^ CRC_POLY;
		end
		return c;
	endfunction

endpackage

module ccfr_scoreboard #(
	parameter int MAX_PAYLOAD = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic             op,
	input  logic [7:0]       byte_in,
	input  logic [7:0]       read_index,
	input  logic             out_valid,
	input  logic             out_ready,
	input  ccfr_pkg::event_t event_res,
	input  logic [7:0]       frame_kind,
	input  logic [15:0]      frame_seq,
	input  logic [8:0]       frame_length,
	input  logic [7:0]       read_data,
	output int               mismatches,
	output int               pending,
	output logic [255:0]     written_map
);

	import ccfr_pkg::*;
	import ccfr_tb_lib::*;

	localparam int HEADER_LEN = 8;

	typedef enum logic [2:0] {
		SEEK_SYNC,
		SEEK_SECOND,
		TAKE_HEADER,
		TAKE_PAYLOAD,
		TAKE_CHECK
	} rx_phase_t;

	typedef struct packed {
		event_t      ev;
		logic [7:0]  kind;
		logic [15:0] seq;
		logic [8:0]  length;
		logic [7:0]  rdata;
	} frame_result_t;

	rx_phase_t     phase;
	logic [3:0]    hdr_taken;
	logic [7:0]    kind_q;
	logic [31:0]   len_q;
	logic [15:0]   seq_q;
	logic [7:0]    payload_mem [0:READ_SPAN-1];
	logic [8:0]    pay_taken;
	logic [7:0]    check_low;
	logic          check_half;
	logic [15:0]   crc_acc;
	frame_result_t expected_q[$];
	int            results_seen;

	// Everything but the kind byte and the buffer goes back to its reset value.
	function automatic void restart_frame();
		phase      = SEEK_SYNC;
		hdr_taken  = '0;
		pay_taken  = '0;
		len_q      = '0;
		seq_q      = '0;
		check_low  = '0;
		check_half = 1'b0;
		crc_acc    = CRC_INIT;
	endfunction

	function automatic frame_result_t predict_item(input logic rd_op, input logic [7:0] b,
			input logic [7:0] idx);
		frame_result_t r;
		r = '0;
		r.ev = EV_NONE;
		if (rd_op == OP_READ) begin
			if (idx < MAX_PAYLOAD)
				r.rdata = payload_mem[idx];
		end else begin
			case (phase)
			SEEK_SECOND: begin
				if (b == MAGIC_SECOND) begin
					hdr_taken = '0;
					crc_acc   = CRC_INIT;
					phase     = TAKE_HEADER;
				end else if (b != MAGIC_FIRST) begin
					phase = SEEK_SYNC;
				end
			end
			TAKE_HEADER: begin
				crc_acc = crc_next(crc_acc, b);
				case (hdr_taken)
				4'd0: kind_q = b;
				4'd2: len_q = {24'h0, b};
				4'd3: len_q[15:8] = b;
				4'd4: len_q[23:16] = b;
				4'd5: len_q[31:24] = b;
				4'd6: seq_q = {8'h00, b};
				4'd7: seq_q[15:8] = b;
				default: ;
				endcase
				hdr_taken++;
				if (hdr_taken >= HEADER_LEN) begin
					if (len_q > MAX_PAYLOAD) begin
						r.ev  = EV_TOO_BIG;
						r.seq = seq_q;
						restart_frame();
					end else if (len_q == 0) begin
						phase = TAKE_CHECK;
					end else begin
						pay_taken = '0;
						phase     = TAKE_PAYLOAD;
					end
				end
			end
			TAKE_PAYLOAD: begin
				if (pay_taken < MAX_PAYLOAD) begin
					payload_mem[pay_taken[7:0]] = b;
					written_map[pay_taken[7:0]] = 1'b1;
				end
				pay_taken++;
				crc_acc = crc_next(crc_acc, b);
				if (pay_taken >= len_q)
					phase = TAKE_CHECK;
			end
			TAKE_CHECK: begin
				if (!check_half) begin
					check_low  = b;
					check_half = 1'b1;
				end else begin
					r.kind = kind_q;
					r.seq  = seq_q;
					if ({b, check_low} == crc_acc) begin
						r.ev     = EV_OK;
						r.length = len_q[8:0];
					end else begin
						r.ev = EV_CRC_BAD;
					end
					restart_frame();
				end
			end
			default: phase = (b == MAGIC_FIRST) ? SEEK_SECOND : SEEK_SYNC;
			endcase
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_result_t got;
		frame_result_t want;
		if (!arst_n) begin
			restart_frame();
			kind_q = '0;
			expected_q.delete();
			written_map  = '0;
			mismatches   = 0;
			pending      = 0;
			results_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{ev: event_res, kind: frame_kind, seq: frame_seq,
					length: frame_length, rdata: read_data};
				results_seen++;
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"[%0t] result %0d arrived with nothing expected: ",
							"ev=%0d kind=%02h seq=%04h len=%0d rd=%02h"},
							$time, results_seen, got.ev, got.kind, got.seq, got.length,
							got.rdata);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("[%0t] result %0d mismatch", $time, results_seen);
							$display("    expected ev=%0d kind=%02h seq=%04h len=%0d rd=%02h",
								want.ev, want.kind, want.seq, want.length, want.rdata);
							$display("    actual   ev=%0d kind=%02h seq=%04h len=%0d rd=%02h",
								got.ev, got.kind, got.seq, got.length, got.rdata);
						end
					end
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(predict_item(op, byte_in, read_index));
			pending = expected_q.size();
		end
	end

endmodule

// ===== tb/crc_checked_frame_receiver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC checked frame receiver testbench
// Feeds framed byte streams (good, corrupted, oversized, cut off, with
// repeated sync bytes) mixed with line noise and buffer reads, under random
// sender bursts and receiver stalls. A checker beside the block predicts and
// compares every result; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module crc_checked_frame_receiver_tb;

	import ccfr_pkg::*;
	import ccfr_tb_lib::*;

	localparam int BUF_DEPTH    = 256;
	localparam int ITEM_TARGET  = 900;
	localparam int STALL_LIMIT  = 5000;
	localparam int LONG_HOLD    = 160;

	typedef enum int {
		RX_OPEN,
		RX_RANDOM,
		RX_PATTERN,
		RX_SPARSE
	} rx_mode_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         in_valid;
	logic         in_ready;
	logic         op;
	logic [7:0]   byte_in;
	logic [7:0]   read_index;
	logic         out_valid;
	logic         out_ready;
	event_t       event_res;
	logic [7:0]   frame_kind;
	logic [15:0]  frame_seq;
	logic [8:0]   frame_length;
	logic [7:0]   read_data;

	int           mismatches;
	int           pending;
	logic [255:0] written_map;

	int           items_sent;
	int           burst_left;
	int           idle_cycles;
	bit           rx_hold_req;
	int           n_good;
	int           n_spoiled;
	int           n_oversized;
	int           n_cut;
	int           n_reads;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	crc_checked_frame_receiver #(
		.MAX_PAYLOAD(BUF_DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.byte_in     (byte_in),
		.read_index  (read_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.event_res   (event_res),
		.frame_kind  (frame_kind),
		.frame_seq   (frame_seq),
		.frame_length(frame_length),
		.read_data   (read_data)
	);

	ccfr_scoreboard #(
		.MAX_PAYLOAD(BUF_DEPTH)
	) checker_u (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.byte_in     (byte_in),
		.read_index  (read_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.event_res   (event_res),
		.frame_kind  (frame_kind),
		.frame_seq   (frame_seq),
		.frame_length(frame_length),
		.read_data   (read_data),
		.mismatches  (mismatches),
		.pending     (pending),
		.written_map (written_map)
	);

	// Only buffer entries that some frame has already filled are read back.
	function automatic logic [7:0] written_index();
		int         start;
		logic [7:0] j;
		start = $urandom_range(255);
		for (int k = 0; k < 256; k++) begin
			j = 8'(start + k);
			if (written_map[j])
				return j;
		end
		return 8'(start);
	endfunction

	function automatic logic [31:0] draw_length();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(0, 8);
		if (r < 95)
			return $urandom_range(9, 40);
		return $urandom_range(41, BUF_DEPTH);
	endfunction

	// One input transaction. The sender works in bursts; between most bursts valid
	// drops for a random number of cycles.
	task automatic put_item(input logic o, input logic [7:0] b, input logic [7:0] idx);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid   <= 1'b1;
		op         <= o;
		byte_in    <= b;
		read_index <= (o == OP_READ) ? written_index() : idx;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (o == OP_READ)
			n_reads++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		put_item(OP_FEED, b, 8'($urandom));
	endtask

	task automatic send_reads(input int n);
		if (written_map != '0)
			repeat (n) put_item(OP_READ, 8'($urandom), 8'h00);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// Builds a whole frame on the line. A length above the buffer size sends
	// the header only; cut >= 0 stops after that many bytes.
	task automatic send_frame(input int extra_bb, input logic [7:0] kind, input logic [15:0] seq,
			input logic [31:0] len_field, input bit spoil, input int cut, input int read_pct);
		logic [7:0]  frame_bytes[$];
		logic [63:0] hdr;
		logic [15:0] crc;
		logic [7:0]  b;
		int          n;
		hdr = {seq, len_field, 8'($urandom), kind};
		crc = CRC_INIT;
		repeat (extra_bb + 1) frame_bytes.push_back(MAGIC_FIRST);
		frame_bytes.push_back(MAGIC_SECOND);
		for (int i = 0; i < 8; i++) begin
			frame_bytes.push_back(hdr[8*i +: 8]);
			crc = crc_next(crc, hdr[8*i +: 8]);
		end
		if (len_field <= BUF_DEPTH) begin
			for (int i = 0; i < len_field; i++) begin
				b = 8'($urandom);
				frame_bytes.push_back(b);
				crc = crc_next(crc, b);
			end
			if (spoil)
				crc = crc ^ (16'h0001 << $urandom_range(15));
			frame_bytes.push_back(crc[7:0]);
			frame_bytes.push_back(crc[15:8]);
		end
		n = (cut >= 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < read_pct)
				send_reads(1);
			send_byte(frame_bytes[i]);
		end
		if (cut >= 0)
			n_cut++;
		else if (len_field > BUF_DEPTH)
			n_oversized++;
		else if (spoil)
			n_spoiled++;
		else
			n_good++;
	endtask

	// Result side: stall patterns that change between random modes, and one
	// long hold-off when the stimulus asks for it.
	initial begin : result_sink
		rx_mode_t mode;
		int       left;
		int       tick;
		bit       hold_served;
		mode = RX_OPEN;
		left = 0;
		tick = 0;
		hold_served = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (rx_hold_req && !hold_served) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				hold_served = 1'b1;
			end else begin
				if (left == 0) begin
					mode = rx_mode_t'($urandom_range(3));
					left = $urandom_range(20, 120);
				end
				left--;
				case (mode)
				RX_OPEN:    out_ready <= 1'b1;
				RX_RANDOM:  out_ready <= ($urandom_range(3) != 0);
				RX_PATTERN: out_ready <= ((tick % 5) >= 2);
				default:    out_ready <= ($urandom_range(9) < 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
				idle_cycles, pending);
			$display("[crc_checked_frame_receiver] ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		int          pick;
		bit          hold_done;
		bit          drain_done;
		logic [31:0] big;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		op          = OP_FEED;
		byte_in     = 8'h00;
		read_index  = 8'h00;
		items_sent  = 0;
		burst_left  = 0;
		rx_hold_req = 1'b0;
		n_good      = 0;
		n_spoiled   = 0;
		n_oversized = 0;
		n_cut       = 0;
		n_reads     = 0;
		hold_done   = 1'b0;
		drain_done  = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A false start, then a zero-length frame behind a doubled sync byte,
		// then a header carrying the largest possible length.
		send_byte(MAGIC_FIRST);
		send_byte(8'h00);
		send_frame(1, 8'hFF, 16'hFFFF, 32'd0, 1'b0, -1, 0);
		send_frame(0, 8'h00, 16'h0000, 32'hFFFF_FFFF, 1'b0, -1, 0);

		// Fill the whole buffer once, then step just past the size limit.
		send_frame(0, 8'($urandom), 16'($urandom), BUF_DEPTH, 1'b0, -1, 3);
		send_frame(0, 8'($urandom), 16'($urandom), BUF_DEPTH + 1, 1'b0, -1, 0);

		while (items_sent < ITEM_TARGET) begin
			if (!hold_done && items_sent > 450) begin
				hold_done   = 1'b1;
				rx_hold_req = 1'b1;
			end
			if (!drain_done && items_sent > 650) begin
				drain_done = 1'b1;
				wait_drained();
			end
			pick = $urandom_range(99);
			if (pick < 55) begin
				send_frame(0, 8'($urandom), 16'($urandom), draw_length(),
					$urandom_range(3) == 0, -1, 8);
			end else if (pick < 63) begin
				send_frame($urandom_range(1, 3), 8'($urandom), 16'($urandom), draw_length(),
					1'b0, -1, 0);
			end else if (pick < 71) begin
				case ($urandom_range(2))
				0: big = BUF_DEPTH + 1;
				1: big = 32'hFFFF_FFFF;
				default: big = $urandom;
				endcase
				if (big <= BUF_DEPTH)
					big = big + BUF_DEPTH + 1;
				send_frame(0, 8'($urandom), 16'($urandom), big, 1'b0, -1, 0);
			end else if (pick < 83) begin
				send_reads($urandom_range(1, 4));
			end else if (pick < 93) begin
				repeat ($urandom_range(1, 5))
					send_byte(($urandom_range(3) == 0) ? MAGIC_FIRST : 8'($urandom));
			end else begin
				// A frame that stops partway through its sync bytes or its header.
				send_frame(0, 8'($urandom), 16'($urandom), draw_length(), 1'b0,
					$urandom_range(1, 9), 0);
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display({"Sent %0d transactions: %0d clean frames, %0d with a bad check, ",
			"%0d oversized, %0d cut short, %0d buffer reads."},
			items_sent, n_good, n_spoiled, n_oversized, n_cut, n_reads);
		$display("Included a long result-side hold-off, a full drain mid-run and %0d mismatches.",
			mismatches);
		if (mismatches == 0 && pending == 0)
			$display("[crc_checked_frame_receiver] OK");
		else
			$display("[crc_checked_frame_receiver] ERROR");
		$finish;
	end

endmodule
